/* sv/mrul_pkg.sv */
// ----------------------------------------------------------------------------
// MRU list package
// Types, codes and constants shared by the MRU list cells and the core.
// ----------------------------------------------------------------------------
package mrul_pkg;

   localparam int DEFAULT_LIST_DEPTH = 32;
   localparam int KEY_W = 32;
   localparam int TIME_W = 32;
   localparam int INDEX_W = 5;
   localparam int COUNT_OUT_W = 6;

   typedef enum logic [1:0] {
      OP_PUSH   = 2'd0,
      OP_TOGGLE = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_READ   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_APPLY,
      ST_SORT,
      ST_ROTATE,
      ST_RESPOND
   } state_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_CLEAR_LINK,
      CELL_SCAN,
      CELL_INSERT,
      CELL_TOGGLE,
      CELL_SORT,
      CELL_ROTATE
   } cell_op_type;

   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic [TIME_W-1:0] stamp;
      logic              pinned;
   } entry_type;

   typedef struct packed {
      cell_op_type      op;
      logic             parity;
      logic [KEY_W-1:0] key;
   } cell_cmd_type;

   typedef struct packed {
      logic found;
      logic pinned;
   } link_type;

   typedef struct packed {
      logic head;
      logic second;
      logic odd;
   } pos_type;

endpackage

/* sv/mrul_cell.sv */
// ----------------------------------------------------------------------------
// MRU list cell
// Holds one list position, finds the first key match through a chain of
// match flags, and moves its entry to or from its neighbors on command.
// ----------------------------------------------------------------------------
module mrul_cell import mrul_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cell_cmd_type cmd,
   input  pos_type      pos,
   input  logic         live,
   input  logic         next_live,
   input  entry_type    prev_entry,
   input  entry_type    next_entry,
   input  link_type     link_prev,
   output entry_type    entry_out,
   output link_type     link_out
);

   entry_type entry_ff, entry_in;
   link_type  link_ff, link_in;
   logic      hit, first, upper_swap, lower_swap;

   always_comb begin
      hit = live && (entry_ff.key == cmd.key);
      first = hit && !link_ff.found;
      link_out.found = link_ff.found | hit;
      link_out.pinned = link_ff.pinned | (first & entry_ff.pinned);
      upper_swap = !pos.head && (pos.odd == cmd.parity) && next_live &&
                   !entry_ff.pinned && next_entry.pinned;
      lower_swap = !pos.head && !pos.second && (pos.odd != cmd.parity) && live &&
                   !prev_entry.pinned && entry_ff.pinned;
   end

   always_comb begin
      entry_in = entry_ff;
      link_in = link_ff;
      unique case (cmd.op)
         CELL_HOLD: begin
         end
         CELL_CLEAR_LINK: begin
            link_in = '0;
         end
         CELL_SCAN: begin
            link_in = link_prev;
         end
         CELL_INSERT: begin
            if (!link_ff.found) begin
               entry_in = prev_entry;
            end
         end
         CELL_TOGGLE: begin
            if (first) begin
               entry_in.pinned = !entry_ff.pinned;
            end
         end
         CELL_SORT: begin
            if (upper_swap) begin
               entry_in = next_entry;
            end else if (lower_swap) begin
               entry_in = prev_entry;
            end
         end
         CELL_ROTATE: begin
            entry_in = next_entry;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (reset) begin
         link_ff <= '0;
      end else begin
         link_ff <= link_in;
      end
   end

   assign entry_out = entry_ff;

endmodule

/* sv/mru_list_with_pinned_entries_core.sv */
// ----------------------------------------------------------------------------
// MRU list with pinned entries
// Most-recent-first list kept in a row of cells; push, toggle, clear, read.
// ----------------------------------------------------------------------------
// Channel   Ports                          Handshake
// request   start, busy, req_*             beat taken when start and not busy
// response  rsp_strobe, rsp_*              one cycle per beat, never stalled
//
// A push runs a match scan down the cell chain, an insert and LIST_DEPTH odd-even
// sort rounds. A toggle runs the scan and a pin toggle, a read a full rotation of
// the chain, and a clear only zeroes the entry count. Reset empties the list; the
// response side cannot stall.
// ----------------------------------------------------------------------------
module mru_list_with_pinned_entries_core import mrul_pkg::*; #(
   parameter int LIST_DEPTH = DEFAULT_LIST_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [1:0]             req_operation,
   input  logic [KEY_W-1:0]       req_entry_key,
   input  logic                   req_pin_request,
   input  logic [TIME_W-1:0]      req_entry_time,
   input  logic [TIME_W-1:0]      req_current_time,
   input  logic [INDEX_W-1:0]     req_read_index,
   output logic                   rsp_strobe,
   output logic [KEY_W-1:0]       rsp_out_key,
   output logic [TIME_W-1:0]      rsp_out_time,
   output logic                   rsp_out_pinned,
   output logic                   rsp_out_valid,
   output logic [COUNT_OUT_W-1:0] rsp_entry_count
);

   localparam int CW = $clog2(LIST_DEPTH);
   localparam int NW = $clog2(LIST_DEPTH + 1);
   localparam int IW = (NW > INDEX_W) ? NW : INDEX_W;

   state_type           state_ff, state_in;
   logic [CW-1:0]       step_ff, step_in;
   logic [NW-1:0]       count_ff, count_in;
   op_type              op_ff, op_in;
   logic [KEY_W-1:0]    key_ff, key_in;
   logic [TIME_W-1:0]   stamp_ff, stamp_in;
   logic                pin_ff, pin_in;
   logic [INDEX_W-1:0]  idx_ff, idx_in;
   entry_type           out_ff, out_in;
   logic                valid_ff, valid_in;

   cell_cmd_type        cmd;
   entry_type           new_entry;
   entry_type           entries [LIST_DEPTH];
   link_type            links [LIST_DEPTH];
   logic [LIST_DEPTH-1:0] live;
   logic                accept, step_last, found;

   assign accept = start && (state_ff == ST_IDLE);
   assign step_last = (step_ff == CW'(LIST_DEPTH - 1));
   assign found = links[LIST_DEPTH-1].found;

   always_comb begin
      new_entry.key = key_ff;
      new_entry.stamp = stamp_ff;
      new_entry.pinned = pin_ff | (found & links[LIST_DEPTH-1].pinned);
   end

   genvar gi;
   generate
      for (gi = 0; gi < LIST_DEPTH; gi++) begin : g_cell
         pos_type   pos;
         entry_type prev_e, next_e;
         link_type  lprev;
         logic      nlive;
         assign live[gi] = (NW'(gi) < count_ff);
         assign pos.head = (gi == 0);
         assign pos.second = (gi == 1);
         assign pos.odd = ((gi % 2) == 1);
         if (gi == 0) begin : g_head
            assign prev_e = new_entry;
            assign lprev = '0;
         end else begin : g_body
            assign prev_e = entries[gi-1];
            assign lprev = links[gi-1];
         end
         if (gi == LIST_DEPTH - 1) begin : g_tail
            assign next_e = entries[0];
            assign nlive = 1'b0;
         end else begin : g_inner
            assign next_e = entries[gi+1];
            assign nlive = live[gi+1];
         end
         mrul_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .cmd        (cmd),
            .pos        (pos),
            .live       (live[gi]),
            .next_live  (nlive),
            .prev_entry (prev_e),
            .next_entry (next_e),
            .link_prev  (lprev),
            .entry_out  (entries[gi]),
            .link_out   (links[gi])
         );
      end
   endgenerate

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (op_type'(req_operation))
                  OP_PUSH, OP_TOGGLE: state_in = ST_SCAN;
                  OP_CLEAR: state_in = ST_RESPOND;
                  OP_READ: state_in = ST_ROTATE;
                  default: state_in = ST_RESPOND;
               endcase
            end
         end
         ST_SCAN: begin
            if (step_ff == CW'(LIST_DEPTH - 2)) begin
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            state_in = (op_ff == OP_PUSH) ? ST_SORT : ST_RESPOND;
         end
         ST_SORT, ST_ROTATE: begin
            if (step_last) begin
               state_in = ST_RESPOND;
            end
         end
         ST_RESPOND: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd.key = key_ff;
      cmd.parity = step_ff[0];
      unique case (state_ff)
         ST_IDLE: cmd.op = CELL_CLEAR_LINK;
         ST_SCAN: cmd.op = CELL_SCAN;
         ST_APPLY: cmd.op = (op_ff == OP_PUSH) ? CELL_INSERT : CELL_TOGGLE;
         ST_SORT: cmd.op = CELL_SORT;
         ST_ROTATE: cmd.op = CELL_ROTATE;
         ST_RESPOND: cmd.op = CELL_HOLD;
         default: cmd.op = CELL_HOLD;
      endcase
   end

   always_comb begin
      step_in = '0;
      count_in = count_ff;
      op_in = op_ff;
      key_in = key_ff;
      stamp_in = stamp_ff;
      pin_in = pin_ff;
      idx_in = idx_ff;
      out_in = out_ff;
      valid_in = valid_ff;
      if (accept) begin
         op_in = op_type'(req_operation);
         key_in = req_entry_key;
         stamp_in = (req_entry_time == '0) ? req_current_time : req_entry_time;
         pin_in = req_pin_request;
         idx_in = req_read_index;
         out_in = '0;
         valid_in = (op_type'(req_operation) == OP_READ) &&
                    (IW'(req_read_index) < IW'(count_ff));
         if (op_type'(req_operation) == OP_CLEAR) begin
            count_in = '0;
         end
      end
      if ((state_ff == ST_SCAN) || (state_ff == ST_SORT) || (state_ff == ST_ROTATE)) begin
         step_in = step_ff + CW'(1);
      end
      if ((state_ff == ST_SCAN) && (state_in != ST_SCAN)) begin
         step_in = '0;
      end
      if ((state_ff == ST_APPLY) && (op_ff == OP_PUSH) && !found &&
          (count_ff != NW'(LIST_DEPTH))) begin
         count_in = count_ff + NW'(1);
      end
      if ((state_ff == ST_ROTATE) && valid_ff && (IW'(step_ff) == IW'(idx_ff))) begin
         out_in = entries[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
         count_ff <= count_in;
      end
      op_ff <= op_in;
      key_ff <= key_in;
      stamp_ff <= stamp_in;
      pin_ff <= pin_in;
      idx_ff <= idx_in;
      out_ff <= out_in;
      valid_ff <= valid_in;
   end

   assign busy = (state_ff != ST_IDLE);
   assign rsp_strobe = (state_ff == ST_RESPOND);
   assign rsp_out_key = out_ff.key;
   assign rsp_out_time = out_ff.stamp;
   assign rsp_out_pinned = out_ff.pinned;
   assign rsp_out_valid = valid_ff;
   assign rsp_entry_count = COUNT_OUT_W'(count_ff);

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= NW'(LIST_DEPTH))
      else $error("entry count beyond list depth");

   a_strobe_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start || busy))
      else $error("response without an accepted beat");

   a_idle_after_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !busy)
      else $error("core still busy after its response");

   a_valid_needs_entries: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_out_valid) |-> (count_ff != '0))
      else $error("valid read from an empty list");

endmodule

/* bench/tb_mru_list_with_pinned_entries_core.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// MRU list with pinned entries testbench
// Drives push, toggle, clear and read beats with random gaps and checks every
// response against a behavioral model of the list kept in the scoreboard.
// ----------------------------------------------------------------------------
import mrul_pkg::*;

class mru_scoreboard;
   logic [KEY_W-1:0]  keys[DEFAULT_LIST_DEPTH];
   logic [TIME_W-1:0] stamps[DEFAULT_LIST_DEPTH];
   logic              pins[DEFAULT_LIST_DEPTH];
   int                used;
   logic [KEY_W-1:0]  exp_key[$];
   logic [TIME_W-1:0] exp_time[$];
   logic              exp_pin[$];
   logic              exp_valid[$];
   logic [5:0]        exp_count[$];
   int                errors;

   function new();
      used = 0;
      errors = 0;
   endfunction

   function int find(logic [KEY_W-1:0] k);
      for (int i = 0; i < used; i++) begin
         if (keys[i] == k) return i;
      end
      return -1;
   endfunction

   function void note_beat(op_type op, logic [KEY_W-1:0] k, logic p,
                           logic [TIME_W-1:0] t, logic [TIME_W-1:0] now,
                           logic [INDEX_W-1:0] idx);
      logic [KEY_W-1:0]  tk[DEFAULT_LIST_DEPTH];
      logic [TIME_W-1:0] tt[DEFAULT_LIST_DEPTH];
      logic              tp[DEFAULT_LIST_DEPTH];
      int m, n;
      logic [KEY_W-1:0]  rk;
      logic [TIME_W-1:0] rt;
      logic rp, rv;
      rk = '0; rt = '0; rp = 0; rv = 0;
      case (op)
         OP_PUSH: begin
            if (t == 0) t = now;
            m = find(k);
            if (m >= 0) begin
               if (!p) p = pins[m];
               used--;
               for (int i = m; i < used; i++) begin
                  keys[i] = keys[i+1]; stamps[i] = stamps[i+1]; pins[i] = pins[i+1];
               end
            end
            for (int i = DEFAULT_LIST_DEPTH - 1; i > 0; i--) begin
               keys[i] = keys[i-1]; stamps[i] = stamps[i-1]; pins[i] = pins[i-1];
            end
            keys[0] = k; stamps[0] = t; pins[0] = p;
            if (used < DEFAULT_LIST_DEPTH) used++;
            n = 0;
            for (int pass = 1; pass >= 0; pass--) begin
               for (int i = 1; i < used; i++) begin
                  if (pins[i] == pass) begin
                     tk[n] = keys[i]; tt[n] = stamps[i]; tp[n] = pins[i]; n++;
                  end
               end
            end
            for (int i = 0; i < n; i++) begin
               keys[i+1] = tk[i]; stamps[i+1] = tt[i]; pins[i+1] = tp[i];
            end
         end
         OP_TOGGLE: begin
            m = find(k);
            if (m >= 0) pins[m] = !pins[m];
         end
         OP_CLEAR: used = 0;
         default: begin
            if (idx < used) begin
               rk = keys[idx]; rt = stamps[idx]; rp = pins[idx]; rv = 1;
            end
         end
      endcase
      exp_key.push_back(rk);
      exp_time.push_back(rt);
      exp_pin.push_back(rp);
      exp_valid.push_back(rv);
      exp_count.push_back(used[5:0]);
   endfunction

   function void check_beat(logic [KEY_W-1:0] k, logic [TIME_W-1:0] t, logic p,
                            logic v, logic [5:0] c);
      if (exp_key.size() == 0) begin
         $display("%0t: unexpected response beat", $time);
         errors++;
         return;
      end
      if (k !== exp_key[0]) begin
         $display("%0t: key expected %h actual %h", $time, exp_key[0], k);
         errors++;
      end
      if (t !== exp_time[0]) begin
         $display("%0t: time expected %h actual %h", $time, exp_time[0], t);
         errors++;
      end
      if (p !== exp_pin[0]) begin
         $display("%0t: pinned expected %b actual %b", $time, exp_pin[0], p);
         errors++;
      end
      if (v !== exp_valid[0]) begin
         $display("%0t: valid expected %b actual %b", $time, exp_valid[0], v);
         errors++;
      end
      if (c !== exp_count[0]) begin
         $display("%0t: count expected %0d actual %0d", $time, exp_count[0], c);
         errors++;
      end
      void'(exp_key.pop_front());
      void'(exp_time.pop_front());
      void'(exp_pin.pop_front());
      void'(exp_valid.pop_front());
      void'(exp_count.pop_front());
   endfunction
endclass

module tb_mru_list_with_pinned_entries_core;
   logic                   clock = 0;
   logic                   reset = 1;
   logic                   start = 0;
   logic                   busy;
   logic [1:0]             req_operation = '0;
   logic [KEY_W-1:0]       req_entry_key = '0;
   logic                   req_pin_request = 0;
   logic [TIME_W-1:0]      req_entry_time = '0;
   logic [TIME_W-1:0]      req_current_time = '0;
   logic [INDEX_W-1:0]     req_read_index = '0;
   logic                   rsp_strobe;
   logic [KEY_W-1:0]       rsp_out_key;
   logic [TIME_W-1:0]      rsp_out_time;
   logic                   rsp_out_pinned;
   logic                   rsp_out_valid;
   logic [COUNT_OUT_W-1:0] rsp_entry_count;

   mru_scoreboard sb = new();
   logic [KEY_W-1:0] key_pool[8];
   int idle_cycles = 0;

   mru_list_with_pinned_entries_core u_dut (.*);

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe)
            sb.check_beat(rsp_out_key, rsp_out_time, rsp_out_pinned, rsp_out_valid,
                          rsp_entry_count);
         if ((start && !busy) || rsp_strobe) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles > 2000) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   task automatic idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return;
      repeat ((r < 95) ? $urandom_range(1, 4) : $urandom_range(20, 150))
         @(negedge clock);
   endtask

   task automatic send_beat(op_type op, logic [KEY_W-1:0] k, logic p,
                            logic [TIME_W-1:0] t, logic [TIME_W-1:0] now,
                            logic [INDEX_W-1:0] idx);
      req_operation <= op;
      req_entry_key <= k;
      req_pin_request <= p;
      req_entry_time <= t;
      req_current_time <= now;
      req_read_index <= idx;
      start <= 1;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note_beat(op, k, p, t, now, idx);
      @(negedge clock);
      start <= 0;
      @(negedge clock);
   endtask

   task automatic random_beat();
      int r;
      op_type op;
      logic [KEY_W-1:0] k;
      r = $urandom_range(0, 99);
      op = (r < 50) ? OP_PUSH : (r < 62) ? OP_TOGGLE : (r < 64) ? OP_CLEAR : OP_READ;
      k = ($urandom_range(0, 9) < 8) ? key_pool[$urandom_range(0, 7)] : $urandom;
      send_beat(op, k, 1'($urandom_range(0, 1)),
                ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom, $urandom,
                5'($urandom_range(0, 31)));
   endtask

   initial begin
      for (int i = 0; i < 8; i++) key_pool[i] = $urandom;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);
      send_beat(OP_READ, '0, 0, '0, '0, 5'd0);
      send_beat(OP_PUSH, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 32'h0, 5'd31);
      send_beat(OP_PUSH, 32'h0, 0, 32'h0, 32'hFFFF_FFFF, 5'd0);
      send_beat(OP_PUSH, 32'h1234, 0, 32'd300, 32'd5, 5'd0);
      send_beat(OP_PUSH, 32'hFFFF_FFFF, 0, 32'd7, 32'd0, 5'd0);
      send_beat(OP_TOGGLE, 32'h0, 0, '0, '0, 5'd0);
      send_beat(OP_TOGGLE, 32'hDEAD, 0, '0, '0, 5'd0);
      for (int i = 0; i < 3; i++) send_beat(OP_READ, '0, 0, '0, '0, i[4:0]);
      send_beat(OP_READ, '0, 0, '0, '0, 5'd3);
      for (int i = 0; i < 34; i++)
         send_beat(OP_PUSH, 32'h100 + i, i[0], i, 32'd1, 5'd0);
      send_beat(OP_READ, '0, 0, '0, '0, 5'd31);
      send_beat(OP_READ, '0, 0, '0, '0, 5'd1);
      send_beat(OP_CLEAR, '0, 0, '0, '0, 5'd0);
      send_beat(OP_READ, '0, 0, '0, '0, 5'd0);
      for (int i = 0; i < 1500; i++) begin
         idle_gap();
         random_beat();
         if (i == 700) begin
            while (sb.exp_key.size() != 0) @(negedge clock);
         end
      end
      while (sb.exp_key.size() != 0) @(negedge clock);
      repeat (80) @(negedge clock);
      if (sb.errors == 0 && sb.exp_key.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule
